FILE: hdl/pot_pkg.sv
package pot_pkg;

    localparam logic [2:0] ACT_RUN       = 3'd0;
    localparam logic [2:0] ACT_CREATE    = 3'd1;
    localparam logic [2:0] ACT_START     = 3'd2;
    localparam logic [2:0] ACT_STOP      = 3'd3;
    localparam logic [2:0] ACT_SET_DELAY = 3'd4;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_INVALID     = 2'd1;
    localparam logic [1:0] ST_NOT_RUNNING = 2'd2;
    localparam logic [1:0] ST_NOT_CREATED = 2'd3;

    // firings reported by one run item at most
    localparam int MAX_ROWS  = 8;
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  channel;
        logic [31:0] delay_ticks;
        logic        periodic;
        logic [31:0] now;
    } pot_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        fired;
        logic [2:0]  fired_channel;
        logic [31:0] due_time;
        logic        last;
    } pot_result_t;

    typedef struct packed {
        logic        go;
        logic [31:0] num;
        logic [31:0] den;
    } pot_div_req_t;

endpackage

FILE: hdl/pot_div.sv
module pot_div
    import pot_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  pot_div_req_t req,
    output logic         done,
    output logic [31:0]  rem
);

    typedef enum logic [1:0] {
        D_IDLE = 2'b01,
        D_RUN  = 2'b10
    } div_state_t;

    div_state_t  state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [31:0] den_reg, den_next;
    logic [31:0] rem_reg, rem_next;
    logic [32:0] shifted;

    // restoring division, one quotient bit per cycle, only the remainder is kept
    assign shifted = {rem_reg, dvd_reg[31]};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        dvd_next   = dvd_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (req.go)
                begin
                    dvd_next   = req.num;
                    den_next   = req.den;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                // the partial remainder stays below the divisor, so 32 bits hold it
                if (shifted >= {1'b0, den_reg})
                    rem_next = 32'(shifted - {1'b0, den_reg});
                else
                    rem_next = shifted[31:0];
                dvd_next = {dvd_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: hdl/periodic_oneshot_timer_bank.sv
// create, start, stop and set delay each give one result, flagged last, from the execute state.
// a run marks due channels in S_MARK, then per firing scans every channel in S_SCAN and picks
// in S_PICK, waiting in S_DIV on the shared serial divider when a periodic channel catches up;
// a last scan that finds nothing, or the MAX_ROWS-th firing, leads to S_FIN, which ends it.
// one item at a time: busy falls in the cycle that carries the last result strobe.
// async active-low reset clears all channels (not created, inactive, zero delay and wakeup).
module periodic_oneshot_timer_bank
    import pot_pkg::*;
#(
    parameter int NUM_TIMERS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  pot_cmd_t    command,
    output logic        strobe,
    output pot_result_t result
);

    localparam int CH_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [CH_W-1:0] LAST_IDX = CH_W'(NUM_TIMERS - 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_MARK = 7'b0000100,
        S_SCAN = 7'b0001000,
        S_PICK = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic        strobe_reg, strobe_next;
    pot_result_t result_reg, result_next;
    pot_cmd_t    cmd_reg, cmd_next;

    logic [31:0] delay_reg [NUM_TIMERS];
    logic [31:0] delay_next [NUM_TIMERS];
    logic [31:0] wake_reg [NUM_TIMERS];
    logic [31:0] wake_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] mode_reg, mode_next;
    logic [NUM_TIMERS-1:0] act_reg, act_next;
    logic [NUM_TIMERS-1:0] crt_reg, crt_next;
    logic [NUM_TIMERS-1:0] due_reg, due_next;

    logic [CH_W-1:0]      idx_reg, idx_next;
    logic                 found_reg, found_next;
    logic [CH_W-1:0]      best_reg, best_next;
    logic [31:0]          best_wake_reg, best_wake_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [CH_W-1:0]      pend_ch_reg, pend_ch_next;
    logic [31:0]          pend_due_reg, pend_due_next;
    logic [ROW_CNT_W-1:0] rows_reg, rows_next;
    logic [31:0]          num_reg, num_next;

    pot_div_req_t div_req;
    logic         div_done;
    logic [31:0]  div_rem;

    logic [CH_W-1:0] ch_idx;
    logic            in_range;
    logic [1:0]      st;
    logic [31:0]     best_delay;
    logic [31:0]     next_time;
    logic [31:0]     catch_num;

    assign ch_idx     = CH_W'(cmd_reg.channel);
    assign in_range   = ({29'd0, cmd_reg.channel} < 32'(NUM_TIMERS));
    assign best_delay = delay_reg[best_reg];
    assign next_time  = best_wake_reg + best_delay;
    // ceiling rounding folded into the dividend; the aligned step is num minus remainder
    assign catch_num  = cmd_reg.now - best_wake_reg + best_delay - 32'd1;

    pot_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .rem   (div_rem)
    );

    always_comb
    begin
        state_next      = state_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;
        cmd_next        = cmd_reg;
        delay_next      = delay_reg;
        wake_next       = wake_reg;
        mode_next       = mode_reg;
        act_next        = act_reg;
        crt_next        = crt_reg;
        due_next        = due_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_wake_next  = best_wake_reg;
        pend_valid_next = pend_valid_reg;
        pend_ch_next    = pend_ch_reg;
        pend_due_next   = pend_due_reg;
        rows_next       = rows_reg;
        num_next        = num_reg;
        div_req         = '0;
        st              = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command;
                    if (command.action == ACT_RUN)
                    begin
                        idx_next        = '0;
                        rows_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_MARK;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC:
            begin
                if (!in_range)
                begin
                    st = ST_INVALID;
                end
                else
                begin
                    case (cmd_reg.action)
                        ACT_CREATE:
                        begin
                            if (cmd_reg.delay_ticks == 32'd0)
                                st = ST_INVALID;
                            else
                            begin
                                delay_next[ch_idx] = cmd_reg.delay_ticks;
                                mode_next[ch_idx]  = cmd_reg.periodic;
                                act_next[ch_idx]   = 1'b0;
                                wake_next[ch_idx]  = '0;
                                crt_next[ch_idx]   = 1'b1;
                            end
                        end
                        ACT_START:
                        begin
                            if (!crt_reg[ch_idx])
                                st = ST_NOT_CREATED;
                            else
                            begin
                                wake_next[ch_idx] = cmd_reg.now + delay_reg[ch_idx];
                                act_next[ch_idx]  = 1'b1;
                            end
                        end
                        ACT_STOP:
                        begin
                            if (!act_reg[ch_idx])
                                st = ST_NOT_RUNNING;
                            else if (!crt_reg[ch_idx])
                                st = ST_NOT_CREATED;
                            else
                            begin
                                act_next[ch_idx]  = 1'b0;
                                wake_next[ch_idx] = '0;
                            end
                        end
                        ACT_SET_DELAY:
                        begin
                            if (cmd_reg.delay_ticks == 32'd0)
                                st = ST_INVALID;
                            else
                            begin
                                delay_next[ch_idx] = cmd_reg.delay_ticks;
                                if (act_reg[ch_idx] && crt_reg[ch_idx])
                                    wake_next[ch_idx] = cmd_reg.now + cmd_reg.delay_ticks;
                            end
                        end
                        default:
                        begin
                            st = ST_INVALID;
                        end
                    endcase
                end
                result_next = '{status: st, fired: 1'b0, fired_channel: 3'd0,
                                due_time: 32'd0, last: 1'b1};
                strobe_next = 1'b1;
                state_next  = S_IDLE;
            end

            S_MARK:
            begin
                due_next[idx_reg] = act_reg[idx_reg] && (wake_reg[idx_reg] <= cmd_reg.now);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
                else
                begin
                    idx_next = idx_reg + CH_W'(1);
                end
            end

            S_SCAN:
            begin
                // strict less-than keeps the lower channel on equal wakeups
                if (due_reg[idx_reg] && (!found_reg || (wake_reg[idx_reg] < best_wake_reg)))
                begin
                    best_next      = idx_reg;
                    best_wake_next = wake_reg[idx_reg];
                    found_next     = 1'b1;
                end
                if (idx_reg == LAST_IDX)
                    state_next = S_PICK;
                else
                    idx_next = idx_reg + CH_W'(1);
            end

            S_PICK:
            begin
                if (!found_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    // a held firing goes out only once it is known not to be the last
                    if (pend_valid_reg)
                    begin
                        result_next = '{status: ST_OK, fired: 1'b1,
                                        fired_channel: 3'(pend_ch_reg),
                                        due_time: pend_due_reg, last: 1'b0};
                        strobe_next = 1'b1;
                    end
                    pend_valid_next    = 1'b1;
                    pend_ch_next       = best_reg;
                    pend_due_next      = best_wake_reg;
                    due_next[best_reg] = 1'b0;
                    rows_next          = rows_reg + ROW_CNT_W'(1);
                    idx_next           = '0;
                    found_next         = 1'b0;
                    if (rows_reg + ROW_CNT_W'(1) == ROW_CNT_W'(MAX_ROWS))
                        state_next = S_FIN;
                    else
                        state_next = S_SCAN;

                    if (mode_reg[best_reg])
                    begin
                        if (best_delay == 32'd0)
                            wake_next[best_reg] = next_time;
                        else if (next_time == cmd_reg.now)
                            wake_next[best_reg] = next_time + best_delay;
                        else if (next_time < cmd_reg.now)
                        begin
                            div_req.go  = 1'b1;
                            div_req.num = catch_num;
                            div_req.den = best_delay;
                            num_next    = catch_num;
                            state_next  = S_DIV;
                        end
                        else
                            wake_next[best_reg] = next_time;
                    end
                    else
                    begin
                        act_next[best_reg]  = 1'b0;
                        wake_next[best_reg] = '0;
                    end
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    wake_next[best_reg] = best_wake_reg + (num_reg - div_rem);
                    if (rows_reg == ROW_CNT_W'(MAX_ROWS))
                        state_next = S_FIN;
                    else
                        state_next = S_SCAN;
                end
            end

            S_FIN:
            begin
                if (pend_valid_reg)
                    result_next = '{status: ST_OK, fired: 1'b1,
                                    fired_channel: 3'(pend_ch_reg),
                                    due_time: pend_due_reg, last: 1'b1};
                else
                    result_next = '{status: ST_OK, fired: 1'b0, fired_channel: 3'd0,
                                    due_time: 32'd0, last: 1'b1};
                strobe_next = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            strobe_reg     <= 1'b0;
            mode_reg       <= '0;
            act_reg        <= '0;
            crt_reg        <= '0;
            due_reg        <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            rows_reg       <= '0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                delay_reg[i] <= '0;
                wake_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            strobe_reg     <= strobe_next;
            mode_reg       <= mode_next;
            act_reg        <= act_next;
            crt_reg        <= crt_next;
            due_reg        <= due_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            rows_reg       <= rows_next;
            delay_reg      <= delay_next;
            wake_reg       <= wake_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg    <= result_next;
        cmd_reg       <= cmd_next;
        best_reg      <= best_next;
        best_wake_reg <= best_wake_next;
        pend_ch_reg   <= pend_ch_next;
        pend_due_reg  <= pend_due_next;
        num_reg       <= num_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule
